>>> src/dri_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dri_pkg
// Shared widths, leg constants, sideband types and the arctangent table for the
// delta robot inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package dri_pkg;

    localparam int POS_W        = 22;  // positions and lengths
    localparam int ANG_W        = 17;  // Q8.8 degrees
    localparam int COEF_W       = 18;  // Q16 leg cosine and sine
    localparam int NRM_W        = 31;  // a, b, c after block scaling
    localparam int DISC_W       = 62;
    localparam int ROOT_W       = 31;
    localparam int CORDIC_STEPS = 23;

    localparam logic signed [ANG_W-1:0] ANG_HALF_TURN = 17'sd46080;

    // legs at 0, 120 and 240 degrees
    localparam logic signed [COEF_W-1:0] LEG_COS [3] = '{
        18'sd65536, -18'sd32768, -18'sd32768
    };
    localparam logic signed [COEF_W-1:0] LEG_SIN [3] = '{
        18'sd0, 18'sd56756, -18'sd56756
    };

    typedef enum logic [2:0] {
        CFG_BASE_OFFSET,
        CFG_UPPER_ARM,
        CFG_LOWER_ARM,
        CFG_ANGLE_UPPER,
        CFG_ANGLE_LOWER,
        CFG_FALLBACK
    } cfg_reg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] offset;
        logic        [POS_W-1:0] upper;
        logic        [POS_W-1:0] lower;
    } geom_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] b;
        logic signed [NRM_W:0]   den;
        logic                    bad;
    } leg_side_t;

    typedef struct packed {
        logic                    no_solution;
        logic signed [ANG_W-1:0] leg_three;
        logic signed [ANG_W-1:0] leg_two;
        logic signed [ANG_W-1:0] leg_one;
    } out_word_t;

    // atan(2^-i) in degrees, Q16
    function automatic logic [21:0] atan_q16(input int step);
        case (step)
            0:       atan_q16 = 22'd2949120;
            1:       atan_q16 = 22'd1740967;
            2:       atan_q16 = 22'd919879;
            3:       atan_q16 = 22'd466945;
            4:       atan_q16 = 22'd234378;
            5:       atan_q16 = 22'd117304;
            6:       atan_q16 = 22'd58666;
            7:       atan_q16 = 22'd29335;
            8:       atan_q16 = 22'd14668;
            9:       atan_q16 = 22'd7334;
            10:      atan_q16 = 22'd3667;
            11:      atan_q16 = 22'd1833;
            12:      atan_q16 = 22'd917;
            13:      atan_q16 = 22'd458;
            14:      atan_q16 = 22'd229;
            15:      atan_q16 = 22'd115;
            16:      atan_q16 = 22'd57;
            17:      atan_q16 = 22'd29;
            18:      atan_q16 = 22'd14;
            19:      atan_q16 = 22'd7;
            20:      atan_q16 = 22'd4;
            21:      atan_q16 = 22'd2;
            22:      atan_q16 = 22'd1;
            default: atan_q16 = 22'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

>>> src/dri_leg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dri_leg_front
// Eight-stage front end of one leg: projection, a, b, c, block scaling and
// the discriminant.
// ----------------------------------------------------------------------------
module dri_leg_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [dri_pkg::POS_W-1:0]      x,
    input  logic signed [dri_pkg::POS_W-1:0]      y,
    input  logic signed [dri_pkg::POS_W-1:0]      z,
    input  logic signed [dri_pkg::COEF_W-1:0]     cq,
    input  logic signed [dri_pkg::COEF_W-1:0]     sq,
    input  dri_pkg::geom_t                        geom,
    output logic                                  out_valid,
    output logic        [dri_pkg::DISC_W-1:0]     disc,
    output dri_pkg::leg_side_t                    side
);
    import dri_pkg::*;

    localparam int STAGES = 8;

    logic [STAGES-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[STAGES-1];

    logic signed [22:0] upper_s, lower_s;
    assign upper_s = signed'({1'b0, geom.upper});
    assign lower_s = signed'({1'b0, geom.lower});

    // stage 1: products
    logic signed [39:0] xc_reg, ys_reg;
    logic signed [43:0] xx_reg, yy_reg, zz_reg, dd_reg;
    logic signed [44:0] lz_reg;
    logic signed [45:0] uu_reg, ll_reg;
    // stage 2
    logic signed [40:0] p_next;
    logic signed [24:0] p_reg;
    logic signed [45:0] q1_reg;
    logic signed [47:0] q2_reg;
    logic signed [49:0] b2_reg;
    // stage 3
    logic signed [25:0] diff_reg;
    logic signed [47:0] dp_reg;
    logic signed [49:0] q_reg, b3_reg;
    // stage 4
    logic signed [49:0] a4_reg, b4_reg, c4_reg;
    // stage 5
    logic        [49:0] abs_a, abs_b, abs_c, mag;
    logic        [4:0]  shift_next, shift_reg;
    logic signed [49:0] a5_reg, b5_reg, c5_reg;
    // stage 6
    logic signed [NRM_W-1:0] a6_reg, b6_reg, c6_reg;
    // stage 7
    logic signed [61:0] aa_reg, bb_reg, cc_reg;
    logic signed [NRM_W:0] den7_reg;
    logic signed [NRM_W-1:0] b7_reg;
    // stage 8
    logic signed [63:0] disc_next;
    logic        [DISC_W-1:0] disc_reg;
    leg_side_t side_reg;

    assign p_next = 41'(xc_reg) + 41'(ys_reg) + 41'sd32768;

    assign abs_a = a4_reg[49] ? 50'(-a4_reg) : 50'(a4_reg);
    assign abs_b = b4_reg[49] ? 50'(-b4_reg) : 50'(b4_reg);
    assign abs_c = c4_reg[49] ? 50'(-c4_reg) : 50'(c4_reg);
    assign mag   = abs_a | abs_b | abs_c;

    // smallest shift that brings every magnitude below 2^30
    always_comb begin
        shift_next = '0;
        for (int i = 30; i < 50; i++) begin
            if (mag[i]) begin
                shift_next = 5'(i - 29);
            end
        end
    end

    assign disc_next = 64'(aa_reg) + 64'(bb_reg) - 64'(cc_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            xc_reg   <= 40'(x) * 40'(cq);
            ys_reg   <= 40'(y) * 40'(sq);
            xx_reg   <= 44'(x) * 44'(x);
            yy_reg   <= 44'(y) * 44'(y);
            zz_reg   <= 44'(z) * 44'(z);
            dd_reg   <= 44'(geom.offset) * 44'(geom.offset);
            lz_reg   <= 45'(upper_s) * 45'(z);
            uu_reg   <= 46'(upper_s) * 46'(upper_s);
            ll_reg   <= 46'(lower_s) * 46'(lower_s);

            p_reg    <= 25'(p_next >>> 16);
            q1_reg   <= 46'(xx_reg) + 46'(yy_reg) + 46'(zz_reg);
            q2_reg   <= 48'(uu_reg) + 48'(dd_reg) - 48'(ll_reg);
            b2_reg   <= -(50'(lz_reg) <<< 1);

            diff_reg <= 26'(geom.offset) - 26'(p_reg);
            dp_reg   <= 48'(geom.offset) * 48'(p_reg);
            q_reg    <= 50'(q1_reg) + 50'(q2_reg);
            b3_reg   <= b2_reg;

            a4_reg   <= (50'(upper_s) * 50'(diff_reg)) <<< 1;
            c4_reg   <= q_reg - (50'(dp_reg) <<< 1);
            b4_reg   <= b3_reg;

            a5_reg    <= a4_reg;
            b5_reg    <= b4_reg;
            c5_reg    <= c4_reg;
            shift_reg <= shift_next;

            a6_reg   <= NRM_W'(a5_reg >>> shift_reg);
            b6_reg   <= NRM_W'(b5_reg >>> shift_reg);
            c6_reg   <= NRM_W'(c5_reg >>> shift_reg);

            aa_reg   <= 62'(a6_reg) * 62'(a6_reg);
            bb_reg   <= 62'(b6_reg) * 62'(b6_reg);
            cc_reg   <= 62'(c6_reg) * 62'(c6_reg);
            den7_reg <= (NRM_W+1)'(c6_reg) - (NRM_W+1)'(a6_reg);
            b7_reg   <= b6_reg;

            disc_reg     <= disc_next[63] ? '0 : DISC_W'(disc_next);
            side_reg.bad <= disc_next[63];
            side_reg.b   <= b7_reg;
            side_reg.den <= den7_reg;
        end
    end

    assign disc = disc_reg;
    assign side = side_reg;

endmodule
`default_nettype wire

>>> src/dri_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dri_sqrt
// Pipelined floor integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module dri_sqrt (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [dri_pkg::DISC_W-1:0]        disc,
    input  dri_pkg::leg_side_t                side_in,
    output logic                              out_valid,
    output logic [dri_pkg::ROOT_W-1:0]        root,
    output dri_pkg::leg_side_t                side_out
);
    import dri_pkg::*;

    localparam int RW = 2 * ROOT_W + 1;

    logic [ROOT_W-1:0] valid_reg;
    logic [RW-1:0]     rem_reg  [ROOT_W];
    logic [RW-1:0]     r_reg    [ROOT_W];
    leg_side_t         side_reg [ROOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[ROOT_W-2:0], in_valid};
        end
    end

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int K = ROOT_W - 1 - j;
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * K);
        logic [RW-1:0] rem_in, r_in, trial;
        leg_side_t     sd_in;

        if (j == 0) begin : g_first
            assign rem_in = RW'(disc);
            assign r_in   = '0;
            assign sd_in  = side_in;
        end else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign r_in   = r_reg[j-1];
            assign sd_in  = side_reg[j-1];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_in >= trial) begin
                    rem_reg[j] <= rem_in - trial;
                    r_reg[j]   <= (r_in >> 1) + BIT;
                end else begin
                    rem_reg[j] <= rem_in;
                    r_reg[j]   <= r_in >> 1;
                end
                side_reg[j] <= sd_in;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = ROOT_W'(r_reg[ROOT_W-1]);
    assign side_out  = side_reg[ROOT_W-1];

endmodule
`default_nettype wire

>>> src/dri_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dri_cordic
// Tangent half-angle to arm angle: numerator and divisor set-up, 23 pipelined
// vectoring steps and the final Q8.8 rounding.
// ----------------------------------------------------------------------------
module dri_cordic (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [dri_pkg::ROOT_W-1:0]          root,
    input  dri_pkg::leg_side_t                  side,
    output logic                                out_valid,
    output logic signed [dri_pkg::ANG_W-1:0]    angle,
    output logic                                bad
);
    import dri_pkg::*;

    localparam int VEC_W  = 36;
    localparam int ACC_W  = 26;
    localparam int STAGES = CORDIC_STEPS + 2;

    logic [STAGES-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    // set-up: num = -b - root, divisor made positive
    logic signed [VEC_W-1:0] num, den;
    assign num = -VEC_W'(side.b) - VEC_W'(signed'({1'b0, root}));
    assign den = VEC_W'(side.den);

    logic signed [VEC_W-1:0] vx_reg   [CORDIC_STEPS+1];
    logic signed [VEC_W-1:0] vy_reg   [CORDIC_STEPS+1];
    logic signed [ACC_W-1:0] acc_reg  [CORDIC_STEPS+1];
    logic                    zero_reg [CORDIC_STEPS+1];
    logic                    bad_reg  [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] zdeg_reg [CORDIC_STEPS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            vx_reg[0]   <= den[VEC_W-1] ? -den : den;
            vy_reg[0]   <= den[VEC_W-1] ? -num : num;
            acc_reg[0]  <= '0;
            zero_reg[0] <= (den == '0);
            bad_reg[0]  <= side.bad || ((den == '0) && (num == '0));
            zdeg_reg[0] <= num[VEC_W-1] ? -ANG_HALF_TURN : ANG_HALF_TURN;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic signed [ACC_W-1:0] ATAN = signed'(ACC_W'(atan_q16(i)));
        logic signed [VEC_W-1:0] dx, dy;
        assign dx = vy_reg[i] >>> i;
        assign dy = vx_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (vy_reg[i][VEC_W-1]) begin
                    vx_reg[i+1]  <= vx_reg[i] - dx;
                    vy_reg[i+1]  <= vy_reg[i] + dy;
                    acc_reg[i+1] <= acc_reg[i] - ATAN;
                end else begin
                    vx_reg[i+1]  <= vx_reg[i] + dx;
                    vy_reg[i+1]  <= vy_reg[i] - dy;
                    acc_reg[i+1] <= acc_reg[i] + ATAN;
                end
                zero_reg[i+1] <= zero_reg[i];
                bad_reg[i+1]  <= bad_reg[i];
                zdeg_reg[i+1] <= zdeg_reg[i];
            end
        end
    end

    // angle = 2*acc, Q16 to Q8.8 rounded
    logic signed [ACC_W+1:0] round_next;
    logic signed [ANG_W-1:0] angle_reg;
    logic                    bad_out_reg;

    assign round_next = ((ACC_W+2)'(acc_reg[CORDIC_STEPS]) <<< 1) + (ACC_W+2)'(128);

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg   <= zero_reg[CORDIC_STEPS] ? zdeg_reg[CORDIC_STEPS]
                                                  : ANG_W'(round_next >>> 8);
            bad_out_reg <= bad_reg[CORDIC_STEPS];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign angle     = angle_reg;
    assign bad       = bad_out_reg;

endmodule
`default_nettype wire

>>> src/delta_robot_inverse_kinematics.sv
`default_nettype none
// ----------------------------------------------------------------------------
// delta_robot_inverse_kinematics
// Rotary delta robot inverse kinematics: target position in, three arm angles out.
// ----------------------------------------------------------------------------
// Takes one target word per clock while s_tready is high and returns one
// angle word per target, in order, through 8 front stages (products, a/b/c,
// block scaling, discriminant), 31 square-root stages (one root bit each), 25
// arctangent stages (set-up, 23 CORDIC steps, rounding) and one clamp stage,
// with the three legs in parallel lanes. A two-word output queue lets the
// pipeline keep taking targets while one result waits; s_tready drops only
// when both slots are full. Configuration writes are taken at any time but
// should be made with the pipeline empty.
module delta_robot_inverse_kinematics #(
    parameter int POSITION_FRAC_BITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // target_x, target_y, target_z, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // leg_one_angle, leg_two_angle, leg_three_angle, pad
    output logic        m_tuser,   // no_solution
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [21:0] cfg_data
);
    import dri_pkg::*;

    localparam longint SCALE      = longint'(1) << POSITION_FRAC_BITS;
    localparam longint OFFSET_RST = (-64'sd11430 * SCALE - 64'sd500000) / 64'sd1000000;
    localparam longint UPPER_RST  = (64'sd192000 * SCALE + 64'sd500000) / 64'sd1000000;
    localparam longint LOWER_RST  = (64'sd242000 * SCALE + 64'sd500000) / 64'sd1000000;

    // configuration
    geom_t                   geom_reg;
    logic signed [ANG_W-1:0] hi_reg, lo_reg, fallback_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geom_reg.offset <= POS_W'(OFFSET_RST);
            geom_reg.upper  <= POS_W'(UPPER_RST);
            geom_reg.lower  <= POS_W'(LOWER_RST);
            hi_reg          <= 17'sd23040;
            lo_reg          <= -17'sd3840;
            fallback_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                CFG_BASE_OFFSET: geom_reg.offset <= signed'(cfg_data);
                CFG_UPPER_ARM:   geom_reg.upper  <= cfg_data;
                CFG_LOWER_ARM:   geom_reg.lower  <= cfg_data;
                CFG_ANGLE_UPPER: hi_reg          <= signed'(cfg_data[ANG_W-1:0]);
                CFG_ANGLE_LOWER: lo_reg          <= signed'(cfg_data[ANG_W-1:0]);
                CFG_FALLBACK:    fallback_reg    <= signed'(cfg_data[ANG_W-1:0]);
                default: ;
            endcase
        end
    end

    // pipeline advance
    logic [1:0] count_reg;
    logic       en;
    assign en       = (count_reg != 2'd2);
    assign s_tready = en;

    logic signed [POS_W-1:0] tx, ty, tz;
    assign tx = signed'(s_tdata[21:0]);
    assign ty = signed'(s_tdata[43:22]);
    assign tz = signed'(s_tdata[65:44]);

    logic                    front_valid [3];
    logic [DISC_W-1:0]       front_disc  [3];
    leg_side_t               front_side  [3];
    logic                    sqrt_valid  [3];
    logic [ROOT_W-1:0]       sqrt_root   [3];
    leg_side_t               sqrt_side   [3];
    logic                    leg_valid   [3];
    logic signed [ANG_W-1:0] leg_angle   [3];
    logic                    leg_bad     [3];

    for (genvar k = 0; k < 3; k++) begin : g_leg
        dri_leg_front u_front (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (s_tvalid),
            .x         (tx),
            .y         (ty),
            .z         (tz),
            .cq        (LEG_COS[k]),
            .sq        (LEG_SIN[k]),
            .geom      (geom_reg),
            .out_valid (front_valid[k]),
            .disc      (front_disc[k]),
            .side      (front_side[k])
        );

        dri_sqrt u_sqrt (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (front_valid[k]),
            .disc      (front_disc[k]),
            .side_in   (front_side[k]),
            .out_valid (sqrt_valid[k]),
            .root      (sqrt_root[k]),
            .side_out  (sqrt_side[k])
        );

        dri_cordic u_cordic (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sqrt_valid[k]),
            .root      (sqrt_root[k]),
            .side      (sqrt_side[k]),
            .out_valid (leg_valid[k]),
            .angle     (leg_angle[k]),
            .bad       (leg_bad[k])
        );
    end

    // clamp and fallback
    logic signed [ANG_W-1:0] clamped [3];
    logic                    any_bad;
    out_word_t               word_next, word_reg;
    logic                    word_valid_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (leg_angle[k] > hi_reg) begin
                clamped[k] = hi_reg;
            end else if (leg_angle[k] < lo_reg) begin
                clamped[k] = lo_reg;
            end else begin
                clamped[k] = leg_angle[k];
            end
        end
    end

    assign any_bad               = leg_bad[0] | leg_bad[1] | leg_bad[2];
    assign word_next.no_solution = any_bad;
    assign word_next.leg_one     = any_bad ? fallback_reg : clamped[0];
    assign word_next.leg_two     = any_bad ? fallback_reg : clamped[1];
    assign word_next.leg_three   = any_bad ? fallback_reg : clamped[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_valid_reg <= 1'b0;
        end else if (en) begin
            word_valid_reg <= leg_valid[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    // two-word output queue, slot 0 is the head
    out_word_t slot0_reg, slot1_reg;
    logic      push, pop;
    assign push = en && word_valid_reg;
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case ({push, pop})
            2'b10: begin
                if (count_reg == 2'd0) begin
                    slot0_reg <= word_reg;
                end else begin
                    slot1_reg <= word_reg;
                end
            end
            2'b01: begin
                slot0_reg <= slot1_reg;
            end
            2'b11: begin
                if (count_reg == 2'd1) begin
                    slot0_reg <= word_reg;
                end else begin
                    slot0_reg <= slot1_reg;
                    slot1_reg <= word_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {5'd0, slot0_reg.leg_three, slot0_reg.leg_two, slot0_reg.leg_one};
    assign m_tuser  = slot0_reg.no_solution;

endmodule
`default_nettype wire

>>> src/dri_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dri_checker
// Port-level checks on the inverse kinematics block, bound to the top level.
// ----------------------------------------------------------------------------
module dri_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // fallback word carries the same angle on all legs
    a_fallback_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            (m_tdata[16:0] == m_tdata[33:17]) && (m_tdata[33:17] == m_tdata[50:34]))
        else $error("fallback angles differ");

    // with the output queue empty the block must take input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output queue");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[55:51] == 5'd0))
        else $error("result pad bits not zero");

endmodule

bind delta_robot_inverse_kinematics dri_checker u_dri_checker (.*);
`default_nettype wire

>>> bench/delta_robot_inverse_kinematics_tb.sv
// ----------------------------------------------------------------------------
// delta_robot_inverse_kinematics_tb
// Drives target positions into the inverse kinematics pipeline and checks each
// angle word against a bit-true predictor, over several geometry and limit
// settings, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module delta_robot_inverse_kinematics_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dri_pkg::*;

    typedef struct {
        logic signed [ANG_W-1:0] leg [3];
        logic                    no_sol;
    } angles_t;

    // geometry and limits as the predictor sees them
    logic signed [21:0] geo_offset;
    logic        [21:0] geo_upper;
    logic        [21:0] geo_lower;
    logic signed [16:0] lim_hi;
    logic signed [16:0] lim_lo;
    logic signed [16:0] fallback;

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned r, bit_q;
        r = 0;
        bit_q = 64'd1 << 62;
        while (bit_q > v) bit_q >>= 2;
        while (bit_q != 0) begin
            if (v >= r + bit_q) begin
                v = v - (r + bit_q);
                r = (r >> 1) + bit_q;
            end else begin
                r >>= 1;
            end
            bit_q >>= 2;
        end
        return longint'(r);
    endfunction

    // returns 0 when the leg cannot reach the target or num and den are both zero
    function automatic bit leg_angle(longint x, longint y, longint z, longint cq, longint sq,
                                     output longint deg);
        longint d, ua, la, p, a, b, c, disc, num, den, vx, vy, acc, dx, dy;
        longint unsigned m;
        int s;
        d = geo_offset;
        ua = longint'(geo_upper);
        la = longint'(geo_lower);
        deg = 0;
        p = fshr(x * cq + y * sq + 32768, 16);
        a = 2 * ua * (d - p);
        b = -2 * ua * z;
        c = x * x + y * y + z * z + ua * ua + d * d - la * la - 2 * d * p;
        m = longint'(a < 0 ? -a : a) | longint'(b < 0 ? -b : b) | longint'(c < 0 ? -c : c);
        s = 0;
        while ((m >> s) >= (64'd1 << 30)) s++;
        a = fshr(a, s);
        b = fshr(b, s);
        c = fshr(c, s);
        disc = a * a + b * b - c * c;
        if (disc < 0) return 0;
        num = -b - isqrt(disc);
        den = c - a;
        if (den == 0) begin
            if (num == 0) return 0;
            deg = num > 0 ? 46080 : -46080;
            return 1;
        end
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        vx = den;
        vy = num;
        acc = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = fshr(vy, i);
            dy = fshr(vx, i);
            if (vy < 0) begin
                vx -= dx; vy += dy; acc -= longint'(atan_q16(i));
            end else begin
                vx += dx; vy -= dy; acc += longint'(atan_q16(i));
            end
        end
        deg = fshr(2 * acc + 128, 8);
        return 1;
    endfunction

    function automatic angles_t solve_angles(logic [71:0] word);
        angles_t r;
        longint x, y, z, v;
        longint cq [3] = '{65536, -32768, -32768};
        longint sq [3] = '{0, 56756, -56756};
        bit ok;
        x = longint'($signed(word[21:0]));
        y = longint'($signed(word[43:22]));
        z = longint'($signed(word[65:44]));
        ok = 1;
        for (int k = 0; k < 3; k++) begin
            if (!leg_angle(x, y, z, cq[k], sq[k], v)) ok = 0;
            if (v > lim_hi) v = lim_hi;
            else if (v < lim_lo) v = lim_lo;
            r.leg[k] = v[16:0];
        end
        if (!ok) for (int k = 0; k < 3; k++) r.leg[k] = fallback;
        r.no_sol = !ok;
        return r;
    endfunction

    class angle_scoreboard;
        angles_t pending [$];
        int errors = 0;

        function void note_target(logic [71:0] word);
            pending.push_back(solve_angles(word));
        endfunction

        function void check_word(logic [55:0] data, logic user);
            angles_t e;
            logic signed [16:0] got [3];
            bit bad;
            got[0] = data[16:0];
            got[1] = data[33:17];
            got[2] = data[50:34];
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h tuser %b", data, user);
                return;
            end
            e = pending.pop_front();
            bad = (user !== e.no_sol);
            for (int k = 0; k < 3; k++) if (got[k] !== e.leg[k]) bad = 1;
            if (bad) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp %0d %0d %0d ns %b got %0d %0d %0d ns %b",
                             e.leg[0], e.leg[1], e.leg[2], e.no_sol,
                             got[0], got[1], got[2], user);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [21:0] cfg_data;

    delta_robot_inverse_kinematics u_top (.*);

    angle_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int quiet_cycles = 0;
    localparam int WATCHDOG = 20000;

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // receiver: ready changes at the falling edge
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_idle);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("simulation failed");
            $finish;
        end
    end

    // valid stays up after the word so that words can follow back to back
    task automatic send_target(logic signed [21:0] x, logic signed [21:0] y,
                               logic signed [21:0] z);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {6'd0, z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_target({6'd0, z, y, x});
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [21:0] value);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_BASE_OFFSET: geo_offset = value;
            CFG_UPPER_ARM:   geo_upper = value;
            CFG_LOWER_ARM:   geo_lower = value;
            CFG_ANGLE_UPPER: lim_hi = value[16:0];
            CFG_ANGLE_LOWER: lim_lo = value[16:0];
            CFG_FALLBACK:    fallback = value[16:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic apply_setting(logic [21:0] off, logic [21:0] ua, logic [21:0] la,
                                 logic [21:0] hi, logic [21:0] lo, logic [21:0] fb);
        write_reg(CFG_BASE_OFFSET, off);
        write_reg(CFG_UPPER_ARM, ua);
        write_reg(CFG_LOWER_ARM, la);
        write_reg(CFG_ANGLE_UPPER, hi);
        write_reg(CFG_ANGLE_LOWER, lo);
        write_reg(CFG_FALLBACK, fb);
        cfg_valid <= 0;
    endtask

    // mostly the reachable workspace, some anywhere in the field range
    task automatic random_target();
        logic signed [21:0] x, y, z;
        if ($urandom_range(99) < 75) begin
            x = 22'($signed($urandom_range(200000)) - 100000);
            y = 22'($signed($urandom_range(200000)) - 100000);
            z = 22'(-$signed($urandom_range(380000, 80000)));
        end else begin
            x = 22'($urandom);
            y = 22'($urandom);
            z = 22'($urandom);
        end
        send_target(x, y, z);
    endtask

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        cfg_valid = 0;
        cfg_index = CFG_BASE_OFFSET;
        cfg_data = '0;
        geo_offset = -22'sd11985;
        geo_upper = 22'd201327;
        geo_lower = 22'd253755;
        lim_hi = 17'sd23040;
        lim_lo = -17'sd3840;
        fallback = 17'sd0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        repeat (4) @(negedge aclk);

        // directed: field extremes, centre, unreachable and degenerate points
        send_target(0, 0, -22'sd250000);
        send_target(0, 0, 0);
        send_target(22'h1fffff, 22'h1fffff, 22'h1fffff);
        send_target(22'h200000, 22'h200000, 22'h200000);
        send_target(22'h1fffff, 22'h200000, 22'h000001);
        send_target(22'h3fffff, 22'h3fffff, 22'h3fffff);
        send_target(100000, 0, -22'sd200000);
        send_target(0, 100000, -22'sd200000);
        send_target(-22'sd100000, -22'sd100000, -22'sd300000);
        send_target(0, 0, -22'sd50000);
        send_target(0, 0, 22'sd400000);
        // pause until everything has come back
        drain();
        // zero-length arms: a zero-over-zero case and unreachable targets
        apply_setting(22'd0, 22'd0, 22'd0, 22'd46080, 22'h3_4c00, 22'h3_4c00);
        send_target(0, 0, 0);
        send_target(1000, 0, 0);
        send_target(0, 0, 5);
        drain();
        apply_setting(22'h200000, 22'h1fffff, 22'h3fffff, 22'h3_4c00, 22'd46080, 22'd46080);
        send_target(0, 0, -22'sd250000);
        send_target(22'h1fffff, 0, 22'h200000);
        send_target(5000, -5000, -22'sd100000);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = phase == 0 ? 16 : phase == 1 ? 45 : 0;
            recv_idle = phase == 0 ? 45 : phase == 1 ? 16 : 0;
            drain();
            case (phase)
                0: apply_setting(-22'sd11985, 22'd201327, 22'd253755,
                                 22'd23040, -22'sd3840, 22'd0);
                1: apply_setting(22'h1fffff, 22'd300000, 22'd500000,
                                 22'd46080, 22'h3_4c00, -22'sd1000);
                default: apply_setting(22'sd20000, 22'd150000, 22'd350000,
                                       -22'sd2000, 22'd3000, 22'h1_ffff);
            endcase
            for (int n = 0; n < 245; n++) random_target();
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
